>>> design/hpq_pkg.sv
// shared types and codes for the max-heap priority queue
`default_nettype none

package hpq_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int OCC_W = 7;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] in_key;
        logic [TAG_W-1:0]        in_tag;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] out_key;
        logic [TAG_W-1:0]        out_tag;
        logic [OCC_W-1:0]        occupancy;
    } t_out_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    // operand pairs of the shared key comparator
    typedef enum logic [1:0] {
        CMP_UP,     // moving entry against its parent
        CMP_CHILD,  // right child against left child
        CMP_DOWN    // larger child against moving entry
    } t_cmp_sel;

endpackage

`default_nettype wire

>>> design/hpq_mem.sv
// heap entry storage: one write port, two registered read ports
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire hpq_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr_a,
    input  wire logic [AW-1:0]   i_raddr_b,
    output hpq_pkg::t_entry      o_rdata_a,
    output hpq_pkg::t_entry      o_rdata_b
);

    hpq_pkg::t_entry r_mem [DEPTH];
    hpq_pkg::t_entry r_rdata_a;
    hpq_pkg::t_entry r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

>>> design/hpq_cmp.sv
// shared signed key comparator with operand selection
`default_nettype none

module hpq_cmp (
    input  wire hpq_pkg::t_cmp_sel       i_sel,
    input  wire logic [hpq_pkg::KEY_W-1:0] i_ent_key,
    input  wire logic [hpq_pkg::KEY_W-1:0] i_child_key,
    input  wire logic [hpq_pkg::KEY_W-1:0] i_rd_a_key,
    input  wire logic [hpq_pkg::KEY_W-1:0] i_rd_b_key,
    output logic                           o_gt
);

    logic [hpq_pkg::KEY_W-1:0] op_a;
    logic [hpq_pkg::KEY_W-1:0] op_b;

    always_comb begin
        unique case (i_sel)
            hpq_pkg::CMP_UP: begin
                op_a = i_ent_key;
                op_b = i_rd_a_key;
            end
            hpq_pkg::CMP_CHILD: begin
                op_a = i_rd_b_key;
                op_b = i_rd_a_key;
            end
            hpq_pkg::CMP_DOWN: begin
                op_a = i_child_key;
                op_b = i_ent_key;
            end
            default: begin
                op_a = i_ent_key;
                op_b = i_rd_a_key;
            end
        endcase
    end

    assign o_gt = $signed(op_a) > $signed(op_b);

endmodule

`default_nettype wire

>>> design/max_heap_priority_queue.sv
// binary max-heap priority queue: sequencer around shared comparator and entry memory
//
//   channel   ports                      direction  transfer
//   command   start, busy, i_item        in         start high while busy low
//   result    o_strobe, o_result         out        o_strobe high for one cycle
//
// insert: the item is taken in idle, then one parent compare per level climbed, up to
// log2(HEAP_DEPTH) levels, with a final write step only where the entry reaches the
// root; extract: root and last entry are fetched, then each level descended takes a
// child compare, then a compare against the moving entry, on the single comparator.
// a full insert or empty extract reports on the next cycle.
// reset empties the heap at once; memory contents are never cleared.
// the result cannot be held off: o_strobe marks it for exactly one cycle.
`default_nettype none

module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire hpq_pkg::t_in_item i_item,
    output logic                   o_strobe,
    output hpq_pkg::t_out_item     o_result
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CC,
        S_DN_CE,
        S_WR_ENT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_fill;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_child_idx;
    hpq_pkg::t_entry    r_ent;
    hpq_pkg::t_entry    r_child;
    hpq_pkg::t_entry    r_root;
    logic               r_strobe;
    hpq_pkg::t_out_item r_res;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    hpq_pkg::t_entry    mem_wdata;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;
    hpq_pkg::t_entry    rd_a;
    hpq_pkg::t_entry    rd_b;
    hpq_pkg::t_cmp_sel  cmp_sel;
    logic               cmp_gt;

    logic [IW-1:0]      fill_w;
    logic [IW-1:0]      left_w;
    logic [IW-1:0]      right_w;
    logic [IW-1:0]      child_left_w;
    logic [IW-1:0]      child_right_w;
    logic [CW-1:0]      fill_m1;
    logic [AW-1:0]      fill_pos;
    logic [AW-1:0]      last_pos;
    logic [AW-1:0]      up_parent;
    logic               heap_full;
    logic [CW+6:0]      fill_ext;
    logic [hpq_pkg::OCC_W-1:0] occ;

    function automatic logic [AW-1:0] par_of(input logic [AW-1:0] p);
        logic [AW-1:0] pm1;
        pm1 = p - 1'b1;
        par_of = (p == '0) ? '0 : (pm1 >> 1);
    endfunction

    assign fill_w        = IW'(r_fill);
    assign left_w        = {1'b0, r_pos, 1'b1};
    assign right_w       = left_w + 1'b1;
    assign child_left_w  = {1'b0, r_child_idx, 1'b1};
    assign child_right_w = child_left_w + 1'b1;
    assign fill_m1       = r_fill - 1'b1;
    assign fill_pos      = r_fill[AW-1:0];
    assign last_pos      = fill_m1[AW-1:0];
    assign up_parent     = par_of(r_pos);
    assign heap_full     = fill_w >= IW'(HEAP_DEPTH);
    assign fill_ext      = (CW + 7)'(r_fill);
    assign occ           = fill_ext[hpq_pkg::OCC_W-1:0];

    hpq_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (rd_a_addr),
        .i_raddr_b (rd_b_addr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    hpq_cmp u_cmp (
        .i_sel       (cmp_sel),
        .i_ent_key   (r_ent.key),
        .i_child_key (r_child.key),
        .i_rd_a_key  (rd_a.key),
        .i_rd_b_key  (rd_b.key),
        .o_gt        (cmp_gt)
    );

    // memory port and comparator control; the moving entry stays in r_ent
    // and is written once where it comes to rest
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_ent;
        rd_a_addr = '0;
        rd_b_addr = '0;
        cmp_sel   = hpq_pkg::CMP_UP;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.cmd == hpq_pkg::CMD_INSERT) begin
                    rd_a_addr = par_of(fill_pos);
                end else if (r_fill != '0) begin
                    rd_b_addr = last_pos;
                end
            end
            S_UP_CMP: begin
                cmp_sel = hpq_pkg::CMP_UP;
                mem_we  = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = rd_a;
                    rd_a_addr = par_of(up_parent);
                end
            end
            S_DN_LOAD: begin
                rd_a_addr = AW'(1);
                if (fill_w > IW'(2)) begin
                    rd_b_addr = AW'(2);
                end
                if (r_fill == CW'(1)) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = rd_b;
                end
            end
            S_DN_CC: begin
                cmp_sel = hpq_pkg::CMP_CHILD;
            end
            S_DN_CE: begin
                cmp_sel = hpq_pkg::CMP_DOWN;
                mem_we  = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = r_child;
                    if (child_left_w < fill_w) begin
                        rd_a_addr = child_left_w[AW-1:0];
                    end
                    if (child_right_w < fill_w) begin
                        rd_b_addr = child_right_w[AW-1:0];
                    end
                end
            end
            S_WR_ENT: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_item.cmd == hpq_pkg::CMD_INSERT) begin
                            if (heap_full) begin
                                r_strobe <= 1'b1;
                                r_res    <= '{hpq_pkg::ST_FULL, '0, '0, occ};
                            end else begin
                                r_ent   <= '{i_item.in_key, i_item.in_tag};
                                r_pos   <= fill_pos;
                                r_fill  <= r_fill + 1'b1;
                                r_root  <= '0;
                                r_state <= (r_fill == '0) ? S_WR_ENT : S_UP_CMP;
                            end
                        end else begin
                            if (r_fill == '0) begin
                                r_strobe <= 1'b1;
                                r_res    <= '{hpq_pkg::ST_EMPTY, '0, '0, occ};
                            end else begin
                                r_fill  <= fill_m1;
                                r_pos   <= '0;
                                r_state <= S_DN_LOAD;
                            end
                        end
                    end
                end
                S_UP_CMP: begin
                    if (cmp_gt) begin
                        r_pos <= up_parent;
                        if (up_parent == '0) begin
                            r_state <= S_WR_ENT;
                        end
                    end else begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res    <= '{hpq_pkg::ST_OK, r_root.key, r_root.tag, occ};
                    end
                end
                S_DN_LOAD: begin
                    r_root <= rd_a;
                    r_ent  <= rd_b;
                    // one entry or none left: nothing to sift
                    if (fill_w <= IW'(1)) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res    <= '{hpq_pkg::ST_OK, rd_a.key, rd_a.tag, occ};
                    end else begin
                        r_state <= S_DN_CC;
                    end
                end
                S_DN_CC: begin
                    // left child wins a tie
                    if (right_w < fill_w && cmp_gt) begin
                        r_child     <= rd_b;
                        r_child_idx <= right_w[AW-1:0];
                    end else begin
                        r_child     <= rd_a;
                        r_child_idx <= left_w[AW-1:0];
                    end
                    r_state <= S_DN_CE;
                end
                S_DN_CE: begin
                    if (cmp_gt) begin
                        r_pos   <= r_child_idx;
                        r_state <= (child_left_w < fill_w) ? S_DN_CC : S_WR_ENT;
                    end else begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res    <= '{hpq_pkg::ST_OK, r_root.key, r_root.tag, occ};
                    end
                end
                S_WR_ENT: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    r_res    <= '{hpq_pkg::ST_OK, r_root.key, r_root.tag, occ};
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

>>> design/hpq_check.sv
// port-level checks for the max-heap priority queue, bound to the top level
`default_nettype none

module hpq_check (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire hpq_pkg::t_out_item o_result
);

    // an accepted command either starts work or reports at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted command neither started nor reported");

    // the block is idle again when it reports
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result reported while still busy");

    // failed operations carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != hpq_pkg::ST_OK) |->
        (o_result.out_key == '0 && o_result.out_tag == '0))
        else $error("failed operation returned an entry");

    // empty report means nothing is held
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == hpq_pkg::ST_EMPTY) |-> (o_result.occupancy == '0))
        else $error("empty report with nonzero occupancy");

    // a result only comes out of an accepted command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result without a command");

endmodule

bind max_heap_priority_queue hpq_check u_hpq_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

>>> tb/tb_max_heap_priority_queue.sv
// testbench for the max-heap priority queue: command stream checked against a shadow heap
`default_nettype none

module tb_max_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import hpq_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_CMDS = 1200;
    localparam int IDLE_PCT = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct {
        t_in_item item;
        bit       no_gap;
        bit       drain;   // hold off until every result is back
    } t_heap_cmd;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_heap_cmd cmd_backlog[$];
    t_out_item due_results[$];

    logic signed [KEY_W-1:0] shadow_key [DEPTH];
    logic [TAG_W-1:0]        shadow_tag [DEPTH];
    int                      shadow_fill = 0;
    int                      errors = 0;
    int                      stall_cycles = 0;

    max_heap_priority_queue #(
        .HEAP_DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void swap_shadow(int a, int b);
        logic signed [KEY_W-1:0] k;
        logic [TAG_W-1:0]        t;
        k = shadow_key[a];
        t = shadow_tag[a];
        shadow_key[a] = shadow_key[b];
        shadow_tag[a] = shadow_tag[b];
        shadow_key[b] = k;
        shadow_tag[b] = t;
    endfunction

    // applies one command to the shadow heap and returns the result it must give
    function automatic t_out_item shadow_heap_apply(t_in_item it);
        t_out_item r;
        int        pos;
        int        parent;
        int        left;
        int        best;
        bit        moving;
        r = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_INSERT) begin
            if (shadow_fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_key[shadow_fill] = it.in_key;
                shadow_tag[shadow_fill] = it.in_tag;
                pos = shadow_fill;
                shadow_fill++;
                moving = 1'b1;
                // climbs only past a strictly smaller parent
                while (pos > 0 && moving) begin
                    parent = (pos - 1) / 2;
                    if (shadow_key[pos] > shadow_key[parent]) begin
                        swap_shadow(pos, parent);
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else if (shadow_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.out_key = shadow_key[0];
            r.out_tag = shadow_tag[0];
            shadow_fill--;
            shadow_key[0] = shadow_key[shadow_fill];
            shadow_tag[0] = shadow_tag[shadow_fill];
            pos = 0;
            moving = 1'b1;
            // left child wins between equal children
            while (moving) begin
                left = 2 * pos + 1;
                best = pos;
                if (left < shadow_fill && shadow_key[left] > shadow_key[best])
                    best = left;
                if (left + 1 < shadow_fill && shadow_key[left + 1] > shadow_key[best])
                    best = left + 1;
                if (best == pos) begin
                    moving = 1'b0;
                end else begin
                    swap_shadow(pos, best);
                    pos = best;
                end
            end
        end
        r.occupancy = OCC_W'(shadow_fill);
        return r;
    endfunction

    function automatic void queue_cmd(logic cmd, logic signed [KEY_W-1:0] key,
                                      logic [TAG_W-1:0] tag, bit no_gap = 1'b0,
                                      bit drain = 1'b0);
        t_heap_cmd c;
        c.item.cmd = cmd;
        c.item.in_key = key;
        c.item.in_tag = tag;
        c.no_gap = no_gap;
        c.drain = drain;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endfunction

    function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin : driver
        bit send;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                due_results.insert(due_results.size(), shadow_heap_apply(i_item));
            if (!start || !busy) begin
                send = cmd_backlog.size() != 0;
                if (send && cmd_backlog[0].drain && due_results.size() != 0)
                    send = 1'b0;
                if (send && !cmd_backlog[0].no_gap && $urandom_range(0, 99) < IDLE_PCT)
                    send = 1'b0;
                if (send) begin
                    i_item <= cmd_backlog[0].item;
                    cmd_backlog.pop_front();
                end
                start <= send;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t ns: result with none expected, got %p", $time, o_result);
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, o_result.status);
                check_field("out_key", want.out_key, o_result.out_key);
                check_field("out_tag", want.out_tag, o_result.out_tag);
                check_field("occupancy", want.occupancy, o_result.occupancy);
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : stimulus
        int                      n;
        int                      phase;
        int                      len;
        int                      insert_pct;
        bit                      calm;
        logic                    cmd;
        logic signed [KEY_W-1:0] key;

        // extremes, ties and the empty case
        queue_cmd(CMD_EXTRACT, KEY_MAX, 16'hffff);
        queue_cmd(CMD_INSERT, KEY_MAX, 16'hffff);
        queue_cmd(CMD_INSERT, KEY_MIN, 16'h0000);
        queue_cmd(CMD_INSERT, '0, 16'h1234);
        queue_cmd(CMD_INSERT, -1, 16'haaaa);
        queue_cmd(CMD_INSERT, 5, 16'h0001);
        queue_cmd(CMD_INSERT, 5, 16'h0002);
        queue_cmd(CMD_INSERT, 5, 16'h0003);
        queue_cmd(CMD_INSERT, KEY_MIN, 16'h5555);
        repeat (8) queue_cmd(CMD_EXTRACT, '0, '0);
        queue_cmd(CMD_EXTRACT, KEY_MIN, 16'h0f0f);
        // equal children below the moving entry
        queue_cmd(CMD_INSERT, 10, 16'h000a);
        queue_cmd(CMD_INSERT, 4, 16'h000b);
        queue_cmd(CMD_INSERT, 4, 16'h000c);
        queue_cmd(CMD_INSERT, 1, 16'h000d);
        queue_cmd(CMD_EXTRACT, '0, '0);

        // random phases: filling, draining and mixed
        n = 0;
        phase = 0;
        while (n < RANDOM_CMDS) begin
            case (phase == 0 ? 0 : $urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            len = (phase == 0) ? 150 : $urandom_range(40, 150);
            calm = (phase == 2);
            for (int i = 0; i < len; i++) begin
                cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: key = $urandom;
                    4, 5, 6: key = KEY_W'(int'($urandom_range(0, 6)) - 3);
                    7: key = KEY_MAX;
                    8: key = KEY_MIN;
                    default: key = $urandom_range(0, 1) ? KEY_MAX - 1 : KEY_MIN + 1;
                endcase
                queue_cmd(cmd, key, TAG_W'($urandom), calm,
                          i == 0 && (phase == 0 || $urandom_range(0, 3) == 0));
            end
            n += len;
            phase++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((cmd_backlog.size() != 0 || start || due_results.size() != 0) &&
               stall_cycles < STALL_LIMIT)
            @(negedge i_clk);
        if (stall_cycles < STALL_LIMIT)
            repeat (TAIL_CYCLES) @(negedge i_clk);
        else
            $display("%0t ns: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);

        if (errors == 0 && stall_cycles < STALL_LIMIT)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
